@@ rtl/sitc_pkg.sv @@
// Shared types and constants for the compacting source identifier table.
// No dependencies; used by every module of the block.
`default_nettype none

package sitc_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ID_W        = 32;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PRESENT   = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_ENC,
		FSM_UPD
	} fsm_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                 capture;
		logic                 add;
		logic                 remove;
		logic [CNT_W-1:0]     count;
		logic [IDX_W-1:0]     hit;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sitc_cell.sv @@
// One table slot: holds an identifier, compares it against the command id
// and takes its upper neighbour's entry on a compacting remove. Uses sitc_pkg.
`default_nettype none

module sitc_cell (
	input  wire logic                          clk,
	input  wire logic [sitc_pkg::IDX_W-1:0]    slot,
	input  wire sitc_pkg::cell_ctrl_t          ctrl,
	input  wire logic [sitc_pkg::ID_W-1:0]     cmp_id,
	input  wire logic [sitc_pkg::ID_W-1:0]     wr_id,
	input  wire logic [sitc_pkg::ID_W-1:0]     next_id,
	output logic      [sitc_pkg::ID_W-1:0]     id_q,
	output logic                               match_q
);

	logic valid;

	assign valid = ({1'b0, slot} < ctrl.count);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			match_q <= valid && (id_q == cmp_id);
		end
		if (ctrl.add && ({1'b0, slot} == ctrl.count)) begin
			id_q <= wr_id;
		end else if (ctrl.remove && (slot >= ctrl.hit)) begin
			id_q <= next_id;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sitc_enc.sv @@
// Match vector to slot index. The table never holds a duplicate, so at most
// one bit is set and an OR of the set positions gives the index. Uses sitc_pkg.
`default_nettype none

module sitc_enc (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic [sitc_pkg::TABLE_DEPTH-1:0]   match,
	output logic      [sitc_pkg::IDX_W-1:0]         hit_s2,
	output logic                                    found_s2
);

	logic [sitc_pkg::IDX_W-1:0] idx;

	always_comb begin
		idx = '0;
		for (int i = 0; i < sitc_pkg::TABLE_DEPTH; i++) begin
			if (match[i]) begin
				idx = idx | sitc_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2   <= idx;
			found_s2 <= |match;
		end
	end

endmodule

`default_nettype wire

@@ rtl/source_id_table_compacting_core.sv @@
// Packed table of up to 64 source identifiers held in a row of slot cells.
// One command at a time: the accept edge latches the compare in every cell,
// the ENC state encodes the single match into an index, and the UPD state
// commits the add or the one-step compacting shift and loads the result
// register. The result register may hold a beat while the next command
// is accepted; the commit cycle waits only if that beat is still untaken.
// Depends on sitc_pkg, sitc_cell and sitc_enc.
`default_nettype none

module source_id_table_compacting_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] src_id,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [5:0]       slot_index
);

	localparam int N = sitc_pkg::TABLE_DEPTH;

	sitc_pkg::fsm_t              state_q, state_d;
	sitc_pkg::cell_ctrl_t        ctrl;
	logic [1:0]                  cmd_q;
	logic [sitc_pkg::ID_W-1:0]   id_q;
	logic [sitc_pkg::CNT_W-1:0]  count_q;
	logic [sitc_pkg::ID_W-1:0]   cell_id [N];
	logic [N-1:0]                match;
	logic [sitc_pkg::IDX_W-1:0]  hit_s2;
	logic                        found_s2;
	logic                        accept, commit, add_ok, rem_ok;
	logic [1:0]                  status_d;
	logic [sitc_pkg::IDX_W-1:0]  slot_d;

	assign in_ready = (state_q == sitc_pkg::FSM_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			id_q  <= src_id;
		end
	end

	// result of the command in hand
	always_comb begin
		status_d = sitc_pkg::ST_NOT_FOUND;
		slot_d   = '0;
		add_ok   = 1'b0;
		rem_ok   = 1'b0;
		case (cmd_q)
			sitc_pkg::CMD_ADD: begin
				if (found_s2) begin
					status_d = sitc_pkg::ST_PRESENT;
				end else if (count_q >= sitc_pkg::CNT_W'(N)) begin
					status_d = sitc_pkg::ST_FULL;
				end else begin
					status_d = sitc_pkg::ST_OK;
					slot_d   = count_q[sitc_pkg::IDX_W-1:0];
					add_ok   = 1'b1;
				end
			end
			sitc_pkg::CMD_REMOVE: begin
				if (found_s2) begin
					status_d = sitc_pkg::ST_OK;
					rem_ok   = 1'b1;
				end
			end
			sitc_pkg::CMD_LOOKUP: begin
				if (found_s2) begin
					status_d = sitc_pkg::ST_OK;
					slot_d   = hit_s2;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		unique case (state_q)
			sitc_pkg::FSM_IDLE: begin
				if (accept) state_d = sitc_pkg::FSM_ENC;
			end
			sitc_pkg::FSM_ENC: begin
				state_d = sitc_pkg::FSM_UPD;
			end
			sitc_pkg::FSM_UPD: begin
				if (!out_valid || out_ready) begin
					commit  = 1'b1;
					state_d = sitc_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = sitc_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sitc_pkg::FSM_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid <= 1'b1;
				if (add_ok) count_q <= count_q + sitc_pkg::CNT_W'(1);
				else if (rem_ok) count_q <= count_q - sitc_pkg::CNT_W'(1);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status     <= status_d;
			slot_index <= slot_d;
		end
	end

	assign ctrl.capture = accept;
	assign ctrl.add     = commit && add_ok;
	assign ctrl.remove  = commit && rem_ok;
	assign ctrl.count   = count_q;
	assign ctrl.hit     = hit_s2;

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [sitc_pkg::ID_W-1:0] nxt;
		if (g == N - 1) begin : g_last
			assign nxt = cell_id[g];
		end else begin : g_mid
			assign nxt = cell_id[g+1];
		end
		sitc_cell u_cell (
			.clk     (clk),
			.slot    (sitc_pkg::IDX_W'(g)),
			.ctrl    (ctrl),
			.cmp_id  (src_id),
			.wr_id   (id_q),
			.next_id (nxt),
			.id_q    (cell_id[g]),
			.match_q (match[g])
		);
	end

	sitc_enc u_enc (
		.clk      (clk),
		.en       (state_q == sitc_pkg::FSM_ENC),
		.match    (match),
		.hit_s2   (hit_s2),
		.found_s2 (found_s2)
	);

endmodule

`default_nettype wire

@@ rtl/sitc_checker.sv @@
// Port-level checks for the compacting source identifier table.
// Depends on sitc_pkg; bound to source_id_table_compacting_core below.
`default_nettype none

module sitc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic [5:0] slot_index
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
		else $error("result beat changed while stalled");

	// only an ok add or lookup carries a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != sitc_pkg::ST_OK) |-> slot_index == 6'd0)
		else $error("slot index non-zero on failed command");

	// one command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("command accepted while another in flight");

endmodule

bind source_id_table_compacting_core sitc_checker u_sitc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.slot_index (slot_index)
);

`default_nettype wire

@@ sim/tb_source_id_table_compacting_core.sv @@
// Self-checking testbench for source_id_table_compacting_core: a directed table
// then shaped random commands, checked beat by beat against a local table model.
// Depends on sitc_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_source_id_table_compacting_core;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         N_DIR      = 22;

	typedef struct packed {
		logic [1:0]                 status;
		logic [sitc_pkg::IDX_W-1:0] slot;
	} table_reply_t;

	// one directed command; typed marks a row whose reply is written out here
	typedef struct packed {
		logic [1:0]                 c;
		logic [sitc_pkg::ID_W-1:0]  id;
		logic                       typed;
		logic [1:0]                 status;
		logic [sitc_pkg::IDX_W-1:0] slot;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 cmd;
	logic [sitc_pkg::ID_W-1:0]  src_id;
	logic                       out_valid;
	logic                       out_ready;
	logic [1:0]                 status;
	logic [sitc_pkg::IDX_W-1:0] slot_index;

	// local copy of the table
	logic [sitc_pkg::ID_W-1:0] tab_ids [sitc_pkg::TABLE_DEPTH];
	int                        tab_count;

	table_reply_t    reply_q [$];
	int              errors;
	int              n_sent;
	int              full_reached;
	int              st_seen [4];
	int              burst_left;
	bit              hold_req;

	dir_row_t dir_rows [N_DIR] = '{
		{sitc_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, sitc_pkg::ST_NOT_FOUND, 6'd0},
		{sitc_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1, sitc_pkg::ST_NOT_FOUND, 6'd0},
		{sitc_pkg::CMD_ADD,    32'h0000_0000, 1'b1, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b1, sitc_pkg::ST_OK,        6'd1},
		{sitc_pkg::CMD_ADD,    32'h0000_0000, 1'b1, sitc_pkg::ST_PRESENT,   6'd0},
		{sitc_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b1, sitc_pkg::ST_PRESENT,   6'd0},
		{sitc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, sitc_pkg::ST_OK,        6'd1},
		{sitc_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_ADD,    32'h5555_5555, 1'b1, sitc_pkg::ST_OK,        6'd2},
		{sitc_pkg::CMD_ADD,    32'hAAAA_AAAA, 1'b1, sitc_pkg::ST_OK,        6'd3},
		{sitc_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_LOOKUP, 32'hAAAA_AAAA, 1'b0, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_REMOVE, 32'hAAAA_AAAA, 1'b0, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_REMOVE, 32'h1234_5678, 1'b1, sitc_pkg::ST_NOT_FOUND, 6'd0},
		{CMD_UNUSED,           32'hFFFF_FFFF, 1'b1, sitc_pkg::ST_NOT_FOUND, 6'd0},
		{CMD_UNUSED,           32'h0000_0000, 1'b1, sitc_pkg::ST_NOT_FOUND, 6'd0},
		{sitc_pkg::CMD_LOOKUP, 32'h8000_0000, 1'b1, sitc_pkg::ST_NOT_FOUND, 6'd0},
		{sitc_pkg::CMD_ADD,    32'h8000_0000, 1'b0, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_ADD,    32'h0000_0001, 1'b0, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, sitc_pkg::ST_OK,        6'd0},
		{sitc_pkg::CMD_LOOKUP, 32'h0000_0001, 1'b0, sitc_pkg::ST_OK,        6'd0}
	};

	source_id_table_compacting_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.src_id     (src_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot_index (slot_index)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("source_id_table_compacting_core test failed");
		$finish;
	end

	// applies one command to the local table, returns the reply it causes
	function automatic table_reply_t table_step(input logic [1:0] c,
			input logic [sitc_pkg::ID_W-1:0] id);
		table_reply_t r;
		int           hit;
		r.status = sitc_pkg::ST_NOT_FOUND;
		r.slot   = '0;
		hit      = -1;
		for (int i = 0; i < tab_count; i++)
			if (hit < 0 && tab_ids[i] == id)
				hit = i;
		case (c)
			sitc_pkg::CMD_ADD: begin
				if (hit >= 0) begin
					r.status = sitc_pkg::ST_PRESENT;
				end else if (tab_count >= sitc_pkg::TABLE_DEPTH) begin
					r.status = sitc_pkg::ST_FULL;
				end else begin
					tab_ids[tab_count] = id;
					r.slot    = sitc_pkg::IDX_W'(tab_count);
					r.status  = sitc_pkg::ST_OK;
					tab_count = tab_count + 1;
					if (tab_count == sitc_pkg::TABLE_DEPTH)
						full_reached++;
				end
			end
			sitc_pkg::CMD_REMOVE: begin
				if (hit >= 0) begin
					// close the gap
					for (int i = hit; i < tab_count - 1; i++)
						tab_ids[i] = tab_ids[i + 1];
					tab_count = tab_count - 1;
					r.status  = sitc_pkg::ST_OK;
				end
			end
			sitc_pkg::CMD_LOOKUP: begin
				if (hit >= 0) begin
					r.slot   = sitc_pkg::IDX_W'(hit);
					r.status = sitc_pkg::ST_OK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// draws a command by percentage; p_hit is the chance of naming a stored id
	function automatic void pick_cmd(input int p_add, input int p_rem, input int p_look,
			input int p_hit, output logic [1:0] c, output logic [sitc_pkg::ID_W-1:0] id);
		int r;
		r = $urandom_range(0, 99);
		if (r < p_add)
			c = sitc_pkg::CMD_ADD;
		else if (r < p_add + p_rem)
			c = sitc_pkg::CMD_REMOVE;
		else if (r < p_add + p_rem + p_look)
			c = sitc_pkg::CMD_LOOKUP;
		else
			c = CMD_UNUSED;
		if (tab_count != 0 && $urandom_range(0, 99) < p_hit)
			id = tab_ids[$urandom_range(0, tab_count - 1)];
		else if ($urandom_range(0, 6) == 0)
			id = $urandom_range(0, 15);
		else
			id = $urandom;
	endfunction

	// called at a falling edge; returns at a falling edge with the next beat free to drive
	task automatic send_cmd(input logic [1:0] c, input logic [sitc_pkg::ID_W-1:0] id,
			input logic typed, input table_reply_t want);
		table_reply_t pred;
		int           gap;
		in_valid <= 1'b1;
		cmd      <= c;
		src_id   <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = table_step(c, id);
		if (typed)
			pred = want;
		reply_q = {reply_q, pred};
		n_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic run_phase(input int n, input int p_add, input int p_rem, input int p_look,
			input int p_hit);
		logic [1:0]                c;
		logic [sitc_pkg::ID_W-1:0] id;
		repeat (n) begin
			pick_cmd(p_add, p_rem, p_look, p_hit, c, id);
			send_cmd(c, id, 1'b0, '0);
		end
	endtask

	// receiver: rotating stall patterns, plus a long hold-off on request
	initial begin : rx_stall
		int mode;
		int mode_cnt;
		int hold_left;
		mode      = 0;
		mode_cnt  = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0)
				hold_left = 400;
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					hold_req = 1'b0;
			end else begin
				mode_cnt++;
				if (mode_cnt == 50) begin
					mode_cnt = 0;
					mode     = $urandom_range(0, 3);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((mode_cnt % 8) < 5);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		table_reply_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			st_seen[status]++;
			if (reply_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d slot %0d", status, slot_index);
			end else begin
				exp_r = reply_q.pop_front();
				if (status !== exp_r.status || slot_index !== exp_r.slot) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
							exp_r.status, exp_r.slot, status, slot_index);
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = sitc_pkg::CMD_ADD;
		src_id     = '0;
		hold_req   = 1'b0;
		errors     = 0;
		n_sent     = 0;
		tab_count  = 0;
		burst_left = 0;
		full_reached = 0;
		foreach (st_seen[i])
			st_seen[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].c, dir_rows[i].id, dir_rows[i].typed,
				{dir_rows[i].status, dir_rows[i].slot});

		// fill to the top, then churn around full
		run_phase(160, 85, 5, 8, 20);
		run_phase(150, 40, 35, 20, 60);

		// sender waits for the pipe to drain
		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		@(negedge clk);

		run_phase(150, 10, 70, 15, 80);
		hold_req = 1'b1;
		run_phase(370, 35, 30, 30, 50);

		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d commands: %0d ok, %0d present, %0d full, %0d not found",
			n_sent, st_seen[sitc_pkg::ST_OK], st_seen[sitc_pkg::ST_PRESENT],
			st_seen[sitc_pkg::ST_FULL], st_seen[sitc_pkg::ST_NOT_FOUND]);
		$display("table filled %0d times, %0d mismatches", full_reached, errors);
		if (errors == 0)
			$display("source_id_table_compacting_core test passed");
		else
			$display("source_id_table_compacting_core test failed");
		$finish;
	end

endmodule

@@ source_id_table_compacting_core.f @@
rtl/sitc_pkg.sv
rtl/sitc_cell.sv
rtl/sitc_enc.sv
rtl/source_id_table_compacting_core.sv
rtl/sitc_checker.sv
sim/tb_source_id_table_compacting_core.sv
